@@ sv/ucf_pkg.sv @@
// shared types and constants for the underrun concealment block
`timescale 1ns / 1ps

package ucf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FADE_W = 16;
  localparam int REC_W = 11;
  localparam int FRM_W = 11;
  localparam int GAIN_W = 17;
  localparam int DIV_NW = 34;
  localparam int PROD_W = 2 * GAIN_W;
  localparam int MAX_CHUNK_DEF = 1024;

  localparam logic [GAIN_W-1:0] UNITY_Q16 = 17'h10000;
  localparam logic [FADE_W-1:0] FADE_RST = 16'd480;
  localparam logic [REC_W-1:0] REC_RST = 11'd48;

  localparam logic CFG_FADE = 1'b0;
  localparam logic CFG_RECOVER = 1'b1;

  typedef struct packed {
    logic start;
    logic [DIV_NW-1:0] num;
    logic [GAIN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [GAIN_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ sv/ucf_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ucf_div import ucf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CntW = $clog2(GAIN_W + 1);

  logic              busy;
  logic              done;
  logic [CntW-1:0]   cnt;
  logic [GAIN_W-1:0] rem;
  logic [GAIN_W-1:0] qsh;
  logic [GAIN_W-1:0] den;
  logic [GAIN_W:0]   trial;
  logic [GAIN_W:0]   diff;
  logic              ge;

  // quotient fits in GAIN_W bits, so the upper numerator bits start below den
  assign trial = {rem, qsh[GAIN_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CntW'(GAIN_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem <= req.num[DIV_NW-1:GAIN_W];
      qsh <= req.num[GAIN_W-1:0];
      den <= req.den;
    end else if (busy) begin
      rem <= ge ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
      qsh <= {qsh[GAIN_W-2:0], ge};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = qsh;

endmodule

@@ sv/underrun_conceal_fade.sv @@
// top level: stereo underrun concealment with fade out and recovery ramp
//
//   channel   dir  fields (lowest bit first)
//   s_axis    in   tdata: left_in, right_in, real_in_chunk; tuser: first_of_chunk, has_sample
//   m_axis    out  tdata: left_out, right_out; tuser: padded, recovering
//   cfg       in   cfg_addr 0 fade_frames, 1 recover_frames
//
// one request at a time; a padding slot skips the divider once fully faded, and
// the first frame of a recovery can use it twice. the shared divider and the
// single registered 17x17 multiplier serve every step of the sequencer.
// reset is synchronous; the control state clears and both registers take their defaults.
// a result waits in the output register while the next request is accepted;
// the sequencer stalls only at the end if that register is still full.
`timescale 1ns / 1ps

module underrun_conceal_fade import ucf_pkg::*; #(
  parameter int MAX_CHUNK = MAX_CHUNK_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [47:0]       s_axis_tdata,  // left_in, right_in, real_in_chunk, zero fill
  input  logic [1:0]        s_axis_tuser,  // first_of_chunk, has_sample
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // left_out, right_out
  output logic [1:0]        m_axis_tuser,  // padded, recovering
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [FADE_W-1:0] cfg_wdata
);

  localparam logic [FADE_W-1:0] MaxChunk = FADE_W'(MAX_CHUNK);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_SGAIN = 13'b0000000000010,
    ST_SGWT  = 13'b0000000000100,
    ST_LMUL  = 13'b0000000001000,
    ST_LEN   = 13'b0000000010000,
    ST_RCHK  = 13'b0000000100000,
    ST_RMUL  = 13'b0000001000000,
    ST_RDIV  = 13'b0000010000000,
    ST_RWT   = 13'b0000100000000,
    ST_MULL  = 13'b0001000000000,
    ST_MULR  = 13'b0010000000000,
    ST_MULD  = 13'b0100000000000,
    ST_OUT   = 13'b1000000000000
  } state_t;

  state_t state;

  logic [FADE_W-1:0]   fade_frames;
  logic [REC_W-1:0]    recover_frames;
  logic [FADE_W-1:0]   starve_count;
  logic [SAMPLE_W-1:0] held_left;
  logic [SAMPLE_W-1:0] held_right;
  logic [GAIN_W-1:0]   base_gain;
  logic [FRM_W-1:0]    ramp_length;
  logic [FRM_W-1:0]    ramp_position;

  logic                has;
  logic [FRM_W-1:0]    real_cnt;
  logic [SAMPLE_W-1:0] x_l;
  logic [SAMPLE_W-1:0] x_r;
  logic [GAIN_W-1:0]   gain;
  logic [SAMPLE_W-1:0] res_l;
  logic [SAMPLE_W-1:0] res_r;
  logic                rec;

  logic [GAIN_W-1:0]   mul_a;
  logic [GAIN_W-1:0]   mul_b;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   prod_rnd;
  logic [GAIN_W-1:0]   mag_rnd;
  logic [GAIN_W-1:0]   mag_l;
  logic [GAIN_W-1:0]   mag_r;

  logic [FRM_W-1:0]    len_raw;
  logic [FRM_W-1:0]    len_cap;
  logic [FRM_W:0]      ramp_den;
  logic [FADE_W-1:0]   fade_diff;
  logic                out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  ucf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign mag_l    = x_l[SAMPLE_W-1] ? GAIN_W'(~{x_l[SAMPLE_W-1], x_l} + 1'b1)
                                    : {1'b0, x_l};
  assign mag_r    = x_r[SAMPLE_W-1] ? GAIN_W'(~{x_r[SAMPLE_W-1], x_r} + 1'b1)
                                    : {1'b0, x_r};
  assign prod_rnd = prod + PROD_W'(32768);
  assign mag_rnd  = prod_rnd[PROD_W-2:GAIN_W-1];
  assign len_raw  = prod_rnd[FRM_W+15:16];
  assign len_cap  = ({5'd0, real_cnt} < MaxChunk) ? real_cnt : MaxChunk[FRM_W-1:0];
  assign ramp_den = {1'b0, ramp_length} + 1'b1;
  assign fade_diff = fade_frames - starve_count;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_LMUL: begin
        mul_a = GAIN_W'(recover_frames);
        mul_b = UNITY_Q16 - gain;
      end
      ST_RMUL: begin
        mul_a = UNITY_Q16 - base_gain;
        mul_b = GAIN_W'(ramp_position) + 1'b1;
      end
      ST_MULL: begin
        mul_a = mag_l;
        mul_b = gain;
      end
      ST_MULR: begin
        mul_a = mag_r;
        mul_b = gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state)
      ST_SGAIN: begin
        div_req.start = (starve_count < fade_frames);
        div_req.num   = DIV_NW'({fade_diff, 17'd0}) + DIV_NW'(fade_frames);
        div_req.den   = {fade_frames, 1'b0};
      end
      ST_RDIV: begin
        div_req.start = 1'b1;
        div_req.num   = {prod[PROD_W-2:0], 1'b0} + DIV_NW'(ramp_den);
        div_req.den   = GAIN_W'({ramp_den, 1'b0});
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_frames    <= FADE_RST;
      recover_frames <= REC_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FADE:    fade_frames    <= cfg_wdata;
        CFG_RECOVER: recover_frames <= cfg_wdata[REC_W-1:0];
        default:     fade_frames    <= fade_frames;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      starve_count  <= '0;
      held_left     <= '0;
      held_right    <= '0;
      base_gain     <= '0;
      ramp_length   <= '0;
      ramp_position <= '0;
    end else begin
      if (state == ST_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser[0]) begin
              ramp_length   <= '0;
              ramp_position <= '0;
            end
            if (!s_axis_tuser[1] || (s_axis_tuser[0] && starve_count != '0)) begin
              state <= ST_SGAIN;
            end else begin
              state <= ST_RCHK;
            end
          end
        end
        ST_SGAIN: begin
          if (starve_count >= fade_frames) begin
            state <= has ? ST_LMUL : ST_MULL;
          end else begin
            state <= ST_SGWT;
          end
        end
        ST_SGWT: begin
          if (div_rsp.done) begin
            state <= has ? ST_LMUL : ST_MULL;
          end
        end
        ST_LMUL: state <= ST_LEN;
        ST_LEN: begin
          ramp_length <= (len_raw > len_cap) ? len_cap : len_raw;
          base_gain   <= gain;
          state       <= ST_RCHK;
        end
        ST_RCHK: begin
          state <= (ramp_position < ramp_length) ? ST_RMUL : ST_OUT;
        end
        ST_RMUL: state <= ST_RDIV;
        ST_RDIV: state <= ST_RWT;
        ST_RWT: begin
          if (div_rsp.done) begin
            ramp_position <= ramp_position + 1'b1;
            state         <= ST_MULL;
          end
        end
        ST_MULL: state <= ST_MULR;
        ST_MULR: state <= ST_MULD;
        ST_MULD: state <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            if (has) begin
              held_left    <= res_l;
              held_right   <= res_r;
              starve_count <= '0;
            end else begin
              ramp_length   <= '0;
              ramp_position <= '0;
              if (starve_count < fade_frames) begin
                starve_count <= starve_count + 1'b1;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          has      <= s_axis_tuser[1];
          real_cnt <= s_axis_tdata[42:32];
          x_l      <= s_axis_tuser[1] ? s_axis_tdata[15:0] : held_left;
          x_r      <= s_axis_tuser[1] ? s_axis_tdata[31:16] : held_right;
          rec      <= 1'b0;
        end
      end
      ST_SGAIN: begin
        if (starve_count >= fade_frames) begin
          gain <= '0;
        end
      end
      ST_SGWT: begin
        if (div_rsp.done) begin
          gain <= div_rsp.quot;
        end
      end
      ST_RCHK: begin
        res_l <= x_l;
        res_r <= x_r;
      end
      ST_RWT: begin
        if (div_rsp.done) begin
          gain <= base_gain + div_rsp.quot;
          rec  <= 1'b1;
        end
      end
      ST_MULR: begin
        res_l <= x_l[SAMPLE_W-1] ? SAMPLE_W'(~mag_rnd + 1'b1) : mag_rnd[SAMPLE_W-1:0];
      end
      ST_MULD: begin
        res_r <= x_r[SAMPLE_W-1] ? SAMPLE_W'(~mag_rnd + 1'b1) : mag_rnd[SAMPLE_W-1:0];
      end
      ST_OUT: begin
        if (out_free) begin
          m_axis_tdata <= {res_r, res_l};
          m_axis_tuser <= {rec, !has};
        end
      end
      default: begin
        gain <= gain;
      end
    endcase
  end

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("padded and recovering both set");

  a_ramp_order: assert property (@(posedge clk) disable iff (rst)
    ramp_position <= ramp_length)
    else $error("ramp position past ramp length");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready held after accept");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULL) |-> (gain <= UNITY_Q16))
    else $error("gain above unity");

endmodule
